// ----- src/mau_pkg.sv -----
`timescale 1ns / 1ps

package mau_pkg;

  // Data path width
  localparam int W = 32;

  // Modulus after reset
  localparam logic [W-1:0] MOD_RESET = W'(64'd4294967291);

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // Reduction cell state: remainders build up one operand bit per cell
  typedef struct packed {
    cmd_t         cmd;
    logic [W-1:0] m;
    logic [W-1:0] xs;
    logic [W-1:0] ys;
    logic [W-1:0] rx;
    logic [W-1:0] ry;
  } red_t;

  // Per-request context carried along the multiply chains
  typedef struct packed {
    cmd_t         cmd;
    logic [W-1:0] m;
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic [W-1:0] e;
    logic [W-1:0] pw;
    logic [W-1:0] quick;
    logic         flag;
  } ctx_t;

  // Multiply cell state: r accumulates a * b, b is consumed MSB first
  typedef struct packed {
    ctx_t         ctx;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] r;
  } mul_t;

  // (a + b) mod m for a, b < m
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  // 1 mod m
  function automatic logic [W-1:0] one_mod(input logic [W-1:0] m);
    return (m == W'(1)) ? '0 : W'(1);
  endfunction

  function automatic ctx_t with_pw(input ctx_t c, input logic [W-1:0] p);
    ctx_t o;
    o = c;
    o.pw = p;
    return o;
  endfunction

endpackage

// ----- src/mau_if.sv -----
`timescale 1ns / 1ps

// Request channel
interface mau_in_if;
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [mau_pkg::W-1:0] operand_a;
  logic [mau_pkg::W-1:0] operand_b;

  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink (input valid, command, operand_a, operand_b, output ready);
endinterface

// Result channel
interface mau_out_if;
  logic                  valid;
  logic                  ready;
  logic [mau_pkg::W-1:0] result;
  logic                  divide_by_zero;

  modport source (output valid, result, divide_by_zero, input ready);
  modport sink (input valid, result, divide_by_zero, output ready);
endinterface

// ----- src/mau_red_cell.sv -----
`timescale 1ns / 1ps

// One restoring-division step on both operands
module mau_red_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  mau_pkg::red_t  in_s,
  output logic           out_v_r,
  output mau_pkg::red_t  out_s_r
);

  logic [mau_pkg::W:0] tx;
  logic [mau_pkg::W:0] ty;
  mau_pkg::red_t       s_nxt;

  // shift in next bit, subtract modulus if it fits
  always_comb begin
    tx = {in_s.rx, in_s.xs[mau_pkg::W-1]};
    ty = {in_s.ry, in_s.ys[mau_pkg::W-1]};
    if (tx >= {1'b0, in_s.m}) tx = tx - {1'b0, in_s.m};
    if (ty >= {1'b0, in_s.m}) ty = ty - {1'b0, in_s.m};
    s_nxt    = in_s;
    s_nxt.rx = tx[mau_pkg::W-1:0];
    s_nxt.ry = ty[mau_pkg::W-1:0];
    s_nxt.xs = in_s.xs << 1;
    s_nxt.ys = in_s.ys << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s_r <= s_nxt;
    end
  end

endmodule

// ----- src/mau_mul_cell.sv -----
`timescale 1ns / 1ps

// One double-and-add step of a modular multiply
module mau_mul_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  mau_pkg::mul_t  in_s,
  output logic           out_v_r,
  output mau_pkg::mul_t  out_s_r
);

  logic [mau_pkg::W-1:0] dbl;
  mau_pkg::mul_t         s_nxt;

  always_comb begin
    dbl   = mau_pkg::add_mod(in_s.r, in_s.r, in_s.ctx.m);
    s_nxt = in_s;
    s_nxt.r = in_s.b[mau_pkg::W-1] ? mau_pkg::add_mod(dbl, in_s.a, in_s.ctx.m) : dbl;
    s_nxt.b = in_s.b << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_s_r <= s_nxt;
    end
  end

endmodule

// ----- src/mau_mul_chain.sv -----
`timescale 1ns / 1ps

// Full modular multiply: a row of W multiply cells
module mau_mul_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  mau_pkg::mul_t  in_s,
  output logic           out_v,
  output mau_pkg::mul_t  out_s
);

  mau_pkg::mul_t s [mau_pkg::W+1];
  logic          v [mau_pkg::W+1];

  assign s[0] = in_s;
  assign v[0] = in_v;

  for (genvar i = 0; i < mau_pkg::W; i++) begin : g_cell
    mau_mul_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (v[i]),
      .in_s    (s[i]),
      .out_v_r (v[i+1]),
      .out_s_r (s[i+1])
    );
  end

  assign out_v = v[mau_pkg::W];
  assign out_s = s[mau_pkg::W];

endmodule

// ----- src/modular_arithmetic_unit.sv -----
`timescale 1ns / 1ps

// Modular arithmetic unit over a configured modulus.
// Requests arrive on in_ch (command, operand_a, operand_b); results leave on
// out_ch (result, divide_by_zero), one result per request, in order.
// Commands: add, subtract, multiply, divide (x * y^(m-2) mod m).
// cfg_we with cfg_wdata writes the modulus; write it only while the unit is empty.
// A modulus of zero behaves as one.
// Throughput: one request per cycle, sustained while out_ch is not stalled.
// Operands are reduced by a row of W division cells and registered in a prep
// stage; the inverse power is a square-and-multiply over W exponent bits, each
// multiply a row of W cells; a last multiply row forms the product, which is
// held in an output register.
// Reset (synchronous, active low) empties the pipeline and loads the modulus
// 4294967291.
// When the receiver stalls, the whole pipeline holds; in_ch.ready drops
// only while a result waits in the output register and out_ch.ready is low.
module modular_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  mau_in_if.sink                in_ch,
  mau_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [mau_pkg::W-1:0] cfg_wdata
);

  localparam int W = mau_pkg::W;

  logic [W-1:0] mod_r;
  logic [W-1:0] m_eff;
  logic         en;

  logic         out_v_r;
  logic [W-1:0] out_res_r;
  logic         out_flag_r;

  // global advance: output register empty or being taken
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mau_pkg::MOD_RESET;
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  assign m_eff = (mod_r == '0) ? W'(1) : mod_r;

  // operand reduction row
  mau_pkg::red_t red_s [W+1];
  logic          red_v [W+1];

  always_comb begin
    red_s[0].cmd = mau_pkg::cmd_t'(in_ch.command);
    red_s[0].m   = m_eff;
    red_s[0].xs  = in_ch.operand_a;
    red_s[0].ys  = in_ch.operand_b;
    red_s[0].rx  = '0;
    red_s[0].ry  = '0;
  end
  assign red_v[0] = in_ch.valid;

  for (genvar i = 0; i < W; i++) begin : g_red
    mau_red_cell u_red (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_v    (red_v[i]),
      .in_s    (red_s[i]),
      .out_v_r (red_v[i+1]),
      .out_s_r (red_s[i+1])
    );
  end

  // prep stage: add/sub result, flag, exponent, initial power
  mau_pkg::ctx_t prep_nxt;
  mau_pkg::ctx_t prep_r;
  logic          prep_v_r;
  logic [W:0]    diff;

  always_comb begin
    prep_nxt.cmd = red_s[W].cmd;
    prep_nxt.m   = red_s[W].m;
    prep_nxt.x   = red_s[W].rx;
    prep_nxt.y   = red_s[W].ry;
    prep_nxt.e   = red_s[W].m - W'(2);
    prep_nxt.pw  = mau_pkg::one_mod(red_s[W].m);
    diff = {1'b0, red_s[W].rx} - {1'b0, red_s[W].ry};
    if (red_s[W].rx < red_s[W].ry) diff = diff + {1'b0, red_s[W].m};
    if (red_s[W].cmd == mau_pkg::CMD_SUB) begin
      prep_nxt.quick = diff[W-1:0];
    end else begin
      prep_nxt.quick = mau_pkg::add_mod(red_s[W].rx, red_s[W].ry, red_s[W].m);
    end
    prep_nxt.flag = (red_s[W].cmd == mau_pkg::CMD_DIV) && (red_s[W].ry == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else if (en) begin
      prep_v_r <= red_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_r <= prep_nxt;
    end
  end

  // exponentiation: square then conditional multiply per exponent bit, MSB first
  mau_pkg::ctx_t ex_ctx [W+1];
  logic          ex_v   [W+1];

  assign ex_ctx[0] = prep_r;
  assign ex_v[0]   = prep_v_r;

  for (genvar j = 0; j < W; j++) begin : g_exp
    mau_pkg::mul_t sq_in;
    mau_pkg::mul_t sq_out;
    mau_pkg::mul_t mu_in;
    mau_pkg::mul_t mu_out;
    logic          sq_v;
    logic          mu_v;

    always_comb begin
      sq_in.ctx = ex_ctx[j];
      sq_in.a   = ex_ctx[j].pw;
      sq_in.b   = ex_ctx[j].pw;
      sq_in.r   = '0;
    end

    mau_mul_chain u_sq (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (ex_v[j]),
      .in_s  (sq_in),
      .out_v (sq_v),
      .out_s (sq_out)
    );

    always_comb begin
      mu_in.ctx = sq_out.ctx;
      mu_in.a   = sq_out.r;
      mu_in.b   = sq_out.ctx.e[W-1-j] ? sq_out.ctx.y : mau_pkg::one_mod(sq_out.ctx.m);
      mu_in.r   = '0;
    end

    mau_mul_chain u_mu (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (sq_v),
      .in_s  (mu_in),
      .out_v (mu_v),
      .out_s (mu_out)
    );

    assign ex_ctx[j+1] = mau_pkg::with_pw(mu_out.ctx, mu_out.r);
    assign ex_v[j+1]   = mu_v;
  end

  // final product: x*y for multiply, x*y^(m-2) for divide
  mau_pkg::mul_t fin_in;
  mau_pkg::mul_t fin_out;
  logic          fin_v;

  always_comb begin
    fin_in.ctx = ex_ctx[W];
    fin_in.a   = ex_ctx[W].x;
    fin_in.b   = (ex_ctx[W].cmd == mau_pkg::CMD_MUL) ? ex_ctx[W].y : ex_ctx[W].pw;
    fin_in.r   = '0;
  end

  mau_mul_chain u_fin (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (ex_v[W]),
    .in_s  (fin_in),
    .out_v (fin_v),
    .out_s (fin_out)
  );

  // output register
  logic [W-1:0] res_nxt;

  always_comb begin
    case (fin_out.ctx.cmd)
      mau_pkg::CMD_ADD, mau_pkg::CMD_SUB: res_nxt = fin_out.ctx.quick;
      default:                            res_nxt = fin_out.ctx.flag ? '0 : fin_out.r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r  <= res_nxt;
      out_flag_r <= fin_out.ctx.flag;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.result         = out_res_r;
  assign out_ch.divide_by_zero = out_flag_r;

  // checks
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> out_ch.result == '0)
    else $error("divide_by_zero with nonzero result");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.result < m_eff || out_ch.result == '0)
    else $error("result not reduced");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("pipeline advance mismatch");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> prep_v_r == $past(prep_v_r))
    else $error("pipeline moved during stall");

endmodule

// ----- bench/modular_arithmetic_unit_tb.sv -----
`timescale 1ns / 1ps

module modular_arithmetic_unit_tb;

  localparam int W = mau_pkg::W;
  localparam int LATENCY = 2114;

  typedef struct packed {
    mau_pkg::cmd_t command;
    logic [W-1:0]  operand_a;
    logic [W-1:0]  operand_b;
  } request_t;

  typedef struct packed {
    logic [W-1:0] result;
    logic         divide_by_zero;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [W-1:0] cfg_wdata = '0;

  mau_in_if in_ch ();
  mau_out_if out_ch ();

  modular_arithmetic_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  request_t pending_q[$];
  answer_t  answer_q[$];
  logic [W-1:0] modulus_now = mau_pkg::MOD_RESET;
  int mismatches = 0;
  longint cycles = 0;
  bit stim_done = 1'b0;

  // Modular helpers at double width, giving the same results as the unit
  function automatic logic [W-1:0] mul_red(logic [W-1:0] a, logic [W-1:0] b,
                                           logic [W-1:0] m);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(p % {{W{1'b0}}, m});
  endfunction

  function automatic answer_t mod_compute(request_t rq, logic [W-1:0] mod_in);
    logic [W-1:0] m, x, y, pw, e;
    logic [W:0] s;
    answer_t ans;
    m = (mod_in == '0) ? W'(1) : mod_in;
    x = rq.operand_a % m;
    y = rq.operand_b % m;
    ans = '0;
    case (rq.command)
      mau_pkg::CMD_ADD: begin
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        ans.result = s[W-1:0];
      end
      mau_pkg::CMD_SUB: ans.result = (x >= y) ? x - y : x + (m - y);
      mau_pkg::CMD_MUL: ans.result = mul_red(x, y, m);
      default: begin
        if (y == '0) begin
          ans.divide_by_zero = 1'b1;
        end else begin
          e = m - W'(2);
          pw = (m == W'(1)) ? '0 : W'(1);
          for (int i = W - 1; i >= 0; i--) begin
            pw = mul_red(pw, pw, m);
            if (e[i]) pw = mul_red(pw, y, m);
          end
          ans.result = mul_red(x, pw, m);
        end
      end
    endcase
    return ans;
  endfunction

  // Request driver: random gap before each request, changes on falling edge
  int send_gap = 0;
  request_t cur_req;
  bit in_fire = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
  end

  // request handshake as seen at the rising edge
  always @(posedge clk) begin
    in_fire = in_ch.valid && in_ch.ready;
  end

  always @(negedge clk) begin
    if (in_fire) begin
      answer_q.push_back(mod_compute(cur_req, modulus_now));
      void'(pending_q.pop_front());
      send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      in_fire = 1'b0;
    end
    if (rst_n && pending_q.size() > 0 && send_gap == 0) begin
      cur_req = pending_q[0];
      in_ch.valid <= 1'b1;
      in_ch.command <= cur_req.command;
      in_ch.operand_a <= cur_req.operand_a;
      in_ch.operand_b <= cur_req.operand_b;
    end else begin
      in_ch.valid <= 1'b0;
      if (send_gap > 0) send_gap--;
    end
  end

  // Result sink: random stall, check at rising edge
  int recv_gap = 0;
  initial out_ch.ready = 1'b0;

  always @(negedge clk) begin
    if (recv_gap > 0) begin
      out_ch.ready <= 1'b0;
      recv_gap--;
    end else begin
      out_ch.ready <= rst_n;
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    cycles++;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.result = out_ch.result;
      got.divide_by_zero = out_ch.divide_by_zero;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got.result);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected result %h dbz %b, got result %h dbz %b",
                     want.result, want.divide_by_zero, got.result, got.divide_by_zero);
        end
      end
      recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    end
    if (cycles > 4000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic request_t rand_req(logic [W-1:0] m);
    request_t rq;
    int pick;
    rq.command = mau_pkg::cmd_t'($urandom_range(0, 3));
    rq.operand_a = $urandom;
    rq.operand_b = $urandom;
    pick = $urandom_range(0, 9);
    if (pick == 0) rq.operand_b = '0;
    else if (pick == 1) rq.operand_b = m;
    else if (pick == 2) rq.operand_a = '1;
    else if (pick == 3) rq.operand_b = m - W'(1);
    else if (pick == 4) rq.operand_a = m * W'($urandom_range(0, 3));
    return rq;
  endfunction

  // Drain both queues, then allow the pipeline to settle
  task automatic drain_all();
    while (pending_q.size() > 0 || answer_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    modulus_now = value;
  endtask

  logic [W-1:0] moduli[9] = '{32'd4294967291, 32'd4294967295, 32'd2, 32'd0, 32'd1,
                              32'd65521, 32'd251, 32'd4294967290, 32'd2147483647};

  initial begin
    request_t rq;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes and every command under the reset modulus
    for (int c = 0; c < 4; c++) begin
      rq.command = mau_pkg::cmd_t'(c);
      rq.operand_a = '1; rq.operand_b = '1; pending_q.push_back(rq);
      rq.operand_a = '0; rq.operand_b = '0; pending_q.push_back(rq);
      rq.operand_a = mau_pkg::MOD_RESET - W'(1); rq.operand_b = mau_pkg::MOD_RESET;
      pending_q.push_back(rq);
      rq.operand_a = 32'd12345; rq.operand_b = mau_pkg::MOD_RESET - W'(1);
      pending_q.push_back(rq);
      rq.operand_a = 32'd5; rq.operand_b = 32'h5555_aaaa; pending_q.push_back(rq);
    end
    drain_all();

    // Random phases over several moduli, including the degenerate ones
    foreach (moduli[i]) begin
      set_modulus(moduli[i]);
      for (int n = 0; n < 95; n++) pending_q.push_back(rand_req(moduli[i]));
      drain_all();
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
